>>> rtl/coo_sparse_scatter_add_macros.svh
// Assertion helpers for the block's top module.
`ifndef COO_SPARSE_SCATTER_ADD_MACROS_SVH
`define COO_SPARSE_SCATTER_ADD_MACROS_SVH

// Checks on every clock edge outside reset that the consequent follows the antecedent.
`define CSS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Checks on every clock edge outside reset that an expression never holds.
`define CSS_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        !(expr)) else $error(msg);

`endif

>>> rtl/css_pkg.sv
package css_pkg;

    localparam int MAX_DIMS    = 4;
    localparam int STORE_DEPTH = 4096;
    localparam int NUM_INDEX   = 4;
    localparam int IDX_W       = 2;
    localparam int COORD_W     = 12;
    localparam int WORD_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int DIMS_CAP    = (MAX_DIMS < NUM_INDEX) ? MAX_DIMS : NUM_INDEX;
    localparam int CNT_W       = $clog2(DIMS_CAP + 1);
    localparam int OFF_W       = 2 * COORD_W + IDX_W;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PROD_W      = 2 * WORD_W;
    localparam int SUM_W       = PROD_W - FRAC_W + 1;
    localparam int NDIM_W      = 3;

    localparam logic signed [WORD_W-1:0] ALPHA_RST = 32'sd65536;

    typedef enum logic [1:0] {
        CMD_ACC   = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        CFG_ALPHA    = 3'd0,
        CFG_NUM_DIMS = 3'd1,
        CFG_STRIDE_0 = 3'd2,
        CFG_STRIDE_1 = 3'd3,
        CFG_STRIDE_2 = 3'd4,
        CFG_STRIDE_3 = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_OFFSET,
        S_ADD,
        S_RDOUT,
        S_PUSH
    } t_state;

    typedef logic [NUM_INDEX-1:0][COORD_W-1:0] t_coord_arr;

    typedef struct packed {
        logic              start;
        logic [NDIM_W-1:0] num_dims;
    } t_off_req;

    typedef struct packed {
        logic             done;
        logic [OFF_W-1:0] offset;
    } t_off_stat;

endpackage

>>> rtl/css_ram.sv
module css_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/css_offset.sv
module css_offset import css_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_off_req   i_req,
    input  t_coord_arr i_index,
    input  t_coord_arr i_stride,
    output t_off_stat  o_stat
);

    logic             r_busy;
    logic [CNT_W-1:0] r_dim;
    logic [CNT_W-1:0] r_last;
    logic [OFF_W-1:0] r_acc;
    t_coord_arr       r_index;

    logic [CNT_W-1:0]     w_eff;
    logic [2*COORD_W-1:0] w_prod;
    logic                 w_done;

    // Dimension counts above what the block supports fall back to the cap.
    assign w_eff = (CNT_W'(i_req.num_dims) > CNT_W'(DIMS_CAP) ||
                    i_req.num_dims > NDIM_W'(DIMS_CAP)) ?
                   CNT_W'(DIMS_CAP) : CNT_W'(i_req.num_dims);

    // One index-times-stride product per cycle into the running offset.
    assign w_prod = r_index[r_dim[IDX_W-1:0]] * i_stride[r_dim[IDX_W-1:0]];
    assign w_done = r_busy && (r_dim == r_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_dim  <= '0;
            r_last <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_dim  <= '0;
            r_last <= w_eff;
        end else if (r_busy) begin
            if (w_done) begin
                r_busy <= 1'b0;
            end else begin
                r_dim <= r_dim + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc   <= '0;
            r_index <= i_index;
        end else if (r_busy && !w_done) begin
            r_acc <= r_acc + OFF_W'(w_prod);
        end
    end

    assign o_stat.done   = w_done;
    assign o_stat.offset = r_acc;

endmodule

>>> rtl/coo_sparse_scatter_add.sv
// Sparse COO scatter-add into a dense store of signed Q16.16 words.
// Input channel: i_in_valid with o_in_stall; a word is taken when valid is
// high and stall is low. It carries a command, four coordinates, an address
// and a value. Output channel: o_out_valid with i_out_stall; every input word
// yields exactly one result word (offset, data, saturated, out_of_range).
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (alpha, num_dims, stride_0..stride_3) at the clock edge; write only while
// the block is idle.
// Sequencing: one word is in work at a time. An accumulate forms its offset
// over the dimensions in use (num_dims capped at four) with one shared 12x12
// multiplier, one dimension a cycle, then reads, adds and writes back on the
// store memory; when the offset lies past the store it goes to the output
// register as out of range without the store access. A write passes from idle
// straight to the push state, a read through a read-out state first. The next
// word is taken after the result is loaded; a result waiting in the output
// register does not block the next word.
// Reset: the control registers take their defaults, then a clearing pass writes
// zero to every store word, one word a cycle, with o_in_stall high.
// Stalling: while i_out_stall holds, the result stays in the output register;
// a following result waits inside the block and new input stalls.
`include "coo_sparse_scatter_add_macros.svh"

module coo_sparse_scatter_add import css_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_command,
    input  logic [COORD_W-1:0]        i_index_0,
    input  logic [COORD_W-1:0]        i_index_1,
    input  logic [COORD_W-1:0]        i_index_2,
    input  logic [COORD_W-1:0]        i_index_3,
    input  logic [COORD_W-1:0]        i_address,
    input  logic signed [WORD_W-1:0]  i_value,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [COORD_W-1:0]        o_offset,
    output logic signed [WORD_W-1:0]  o_data,
    output logic                      o_saturated,
    output logic                      o_out_of_range,
    input  logic                      i_cfg_we,
    input  logic [2:0]                i_cfg_index,
    input  logic [WORD_W-1:0]         i_cfg_data
);

    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(STORE_DEPTH - 1);
    localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'({1'b0, {(WORD_W-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] SUM_LO = ~SUM_HI;

    // Configuration registers.
    logic signed [WORD_W-1:0] r_alpha;
    logic [NDIM_W-1:0]        r_num_dims;
    t_coord_arr               r_stride;

    t_state r_state, n_state;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [ADDR_W-1:0] r_acc_addr, n_acc_addr;
    logic signed [PROD_W-1:0] r_prod;

    logic [COORD_W-1:0]       r_res_off, n_res_off;
    logic signed [WORD_W-1:0] r_res_data, n_res_data;
    logic                     r_res_sat, n_res_sat;
    logic                     r_res_oor, n_res_oor;

    logic                     r_out_valid, n_out_valid;
    logic [COORD_W-1:0]       r_out_off;
    logic signed [WORD_W-1:0] r_out_data;
    logic                     r_out_sat;
    logic                     r_out_oor;
    logic                     w_load;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [WORD_W-1:0] mem_wdata, mem_rdata;

    t_off_req   off_req;
    t_off_stat  off_stat;
    t_coord_arr w_index;

    logic                     w_off_oor, w_addr_oor;
    logic signed [SUM_W-1:0]  w_cur, w_shift, w_sum;
    logic signed [WORD_W-1:0] w_sum_sat;
    logic                     w_sat;

    assign w_index = {i_index_3, i_index_2, i_index_1, i_index_0};

    css_offset u_offset (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (off_req),
        .i_index  (w_index),
        .i_stride (r_stride),
        .o_stat   (off_stat)
    );

    css_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (WORD_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign w_off_oor  = 32'(off_stat.offset) >= 32'(STORE_DEPTH);
    assign w_addr_oor = 32'(i_address) >= 32'(STORE_DEPTH);

    // The arithmetic shift of the full product rounds toward minus infinity.
    assign w_cur     = SUM_W'($signed(mem_rdata));
    assign w_shift   = SUM_W'(r_prod >>> FRAC_W);
    assign w_sum     = w_cur + w_shift;
    assign w_sat     = (w_sum > SUM_HI) || (w_sum < SUM_LO);
    assign w_sum_sat = (w_sum > SUM_HI) ? WORD_W'(SUM_HI) :
                       (w_sum < SUM_LO) ? WORD_W'(SUM_LO) : WORD_W'(w_sum);

    always_comb begin
        n_state     = r_state;
        n_acc_addr  = r_acc_addr;
        n_res_off   = r_res_off;
        n_res_data  = r_res_data;
        n_res_sat   = r_res_sat;
        n_res_oor   = r_res_oor;
        mem_we      = 1'b0;
        mem_waddr   = r_acc_addr;
        mem_wdata   = w_sum_sat;
        mem_re      = 1'b0;
        mem_raddr   = ADDR_W'(off_stat.offset);
        off_req     = '0;
        off_req.num_dims = r_num_dims;
        w_load      = 1'b0;

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
                if (r_clr_addr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_command)
                        CMD_ACC: begin
                            off_req.start = 1'b1;
                            n_state = S_OFFSET;
                        end
                        CMD_WRITE, CMD_READ: begin
                            if (w_addr_oor) begin
                                n_res_off  = '0;
                                n_res_data = '0;
                                n_res_sat  = 1'b0;
                                n_res_oor  = 1'b1;
                                n_state    = S_PUSH;
                            end else if (i_command == CMD_WRITE) begin
                                mem_we     = 1'b1;
                                mem_waddr  = ADDR_W'(i_address);
                                mem_wdata  = i_value;
                                n_res_off  = i_address;
                                n_res_data = i_value;
                                n_res_sat  = 1'b0;
                                n_res_oor  = 1'b0;
                                n_state    = S_PUSH;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = ADDR_W'(i_address);
                                n_res_off = i_address;
                                n_state   = S_RDOUT;
                            end
                        end
                        default: begin
                            n_res_off  = '0;
                            n_res_data = '0;
                            n_res_sat  = 1'b0;
                            n_res_oor  = 1'b0;
                            n_state    = S_PUSH;
                        end
                    endcase
                end
            end
            S_OFFSET: begin
                if (off_stat.done) begin
                    if (w_off_oor) begin
                        n_res_off  = '0;
                        n_res_data = '0;
                        n_res_sat  = 1'b0;
                        n_res_oor  = 1'b1;
                        n_state    = S_PUSH;
                    end else begin
                        mem_re     = 1'b1;
                        n_acc_addr = ADDR_W'(off_stat.offset);
                        n_res_off  = COORD_W'(off_stat.offset);
                        n_state    = S_ADD;
                    end
                end
            end
            S_ADD: begin
                // The read of this word finished last cycle; write the sum back.
                mem_we     = 1'b1;
                n_res_data = w_sum_sat;
                n_res_sat  = w_sat;
                n_res_oor  = 1'b0;
                n_state    = S_PUSH;
            end
            S_RDOUT: begin
                n_res_data = $signed(mem_rdata);
                n_res_sat  = 1'b0;
                n_res_oor  = 1'b0;
                n_state    = S_PUSH;
            end
            S_PUSH: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = w_load || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha    <= ALPHA_RST;
            r_num_dims <= NDIM_W'(1);
            r_stride   <= {COORD_W'(0), COORD_W'(0), COORD_W'(0), COORD_W'(1)};
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ALPHA:    r_alpha     <= $signed(i_cfg_data);
                CFG_NUM_DIMS: r_num_dims  <= i_cfg_data[NDIM_W-1:0];
                CFG_STRIDE_0: r_stride[0] <= i_cfg_data[COORD_W-1:0];
                CFG_STRIDE_1: r_stride[1] <= i_cfg_data[COORD_W-1:0];
                CFG_STRIDE_2: r_stride[2] <= i_cfg_data[COORD_W-1:0];
                CFG_STRIDE_3: r_stride[3] <= i_cfg_data[COORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc_addr <= n_acc_addr;
        r_res_off  <= n_res_off;
        r_res_data <= n_res_data;
        r_res_sat  <= n_res_sat;
        r_res_oor  <= n_res_oor;
        if (r_state == S_IDLE && i_in_valid) begin
            r_prod <= r_alpha * i_value;
        end
        if (w_load) begin
            r_out_off  <= r_res_off;
            r_out_data <= r_res_data;
            r_out_sat  <= r_res_sat;
            r_out_oor  <= r_res_oor;
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_offset       = r_out_off;
    assign o_data         = r_out_data;
    assign o_saturated    = r_out_sat;
    assign o_out_of_range = r_out_oor;

    `CSS_ASSERT_NEVER(a_rw_same_cycle, mem_we && mem_re, "store read and write in one cycle")
    `CSS_ASSERT_IMPLY(a_we_states, mem_we,
        r_state == S_CLEAR || r_state == S_ADD || r_state == S_IDLE,
        "store written outside clear, add or idle")
    `CSS_ASSERT_IMPLY(a_oor_clean, o_out_valid && o_out_of_range,
        o_data == '0 && o_offset == '0 && !o_saturated,
        "out-of-range result carries data")
    `CSS_ASSERT_IMPLY(a_push_hold, r_state == S_PUSH && r_out_valid && i_out_stall,
        ##1 r_state == S_PUSH, "pending result left before the output was free")

endmodule
